[src/ctmt_pkg.sv]
package ctmt_pkg;

  localparam int DEF_MAX_ENTRIES = 1024;
  localparam int DEF_COUNT_BITS  = 16;

  localparam int FUNC_W      = 2;
  localparam int ENTRY_W     = 10;
  localparam int OUT_COUNT_W = 16;
  localparam int AT_MAX_W    = 11;
  localparam int STATUS_W    = 2;
  localparam int CFG_W       = 11;

  localparam logic [CFG_W-1:0] CFG_RESET = 11'd1024;

  localparam logic [FUNC_W-1:0] FUNC_INC = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_DEC = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CLR = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_SAT   = 2'd2;

  typedef struct packed {
    logic [FUNC_W-1:0]  func;
    logic [ENTRY_W-1:0] entry;
  } in_item_t;

  typedef struct packed {
    logic [OUT_COUNT_W-1:0] entry_count;
    logic [OUT_COUNT_W-1:0] max_count;
    logic [AT_MAX_W-1:0]    entries_at_max;
    logic [STATUS_W-1:0]    status;
  } out_item_t;

  typedef struct packed {
    logic cfg_write;
    logic clr_step;
    logic accept;
    logic exec;
    logic scan_start;
    logic scan_step;
    logic load_out;
  } ctmt_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic need_rescan;
    logic scan_done;
  } ctmt_stat_t;

endpackage

[src/ctmt_dp.sv]
module ctmt_dp #(
  parameter int MAX_ENTRIES = ctmt_pkg::DEF_MAX_ENTRIES,
  parameter int COUNT_BITS  = ctmt_pkg::DEF_COUNT_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  ctmt_pkg::ctmt_cmd_t           cmd,
  output ctmt_pkg::ctmt_stat_t          stat,
  input  ctmt_pkg::in_item_t            in_data,
  input  logic [ctmt_pkg::CFG_W-1:0]    cfg_data,
  output ctmt_pkg::out_item_t           out_data
);

  localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int AW = $clog2(MAX_ENTRIES + 1);
  localparam int CW = COUNT_BITS;

  logic [CW-1:0] mem [MAX_ENTRIES];
  logic [CW-1:0] rd_data;

  ctmt_pkg::in_item_t         item;
  logic [ctmt_pkg::CFG_W-1:0] entries_in_use;
  logic [CW-1:0]              cur_max;
  logic [AW-1:0]              cnt_max;
  logic [IW-1:0]              clr_idx;
  logic [AW-1:0]              scan_idx;
  logic                       scan_pend;
  logic [CW-1:0]              res_count;
  logic [ctmt_pkg::STATUS_W-1:0] res_status;

  logic [AW-1:0]  active;
  logic           in_range;
  logic [CW-1:0]  new_c;
  logic [CW-1:0]  res_count_c;
  logic           do_wr;
  logic           sat;
  logic           lower;
  logic           rescan;
  logic [CW-1:0]  max_next;
  logic [AW-1:0]  cnt_next;
  logic [ctmt_pkg::STATUS_W-1:0] status_c;
  logic           scan_rd;

  function automatic logic [AW-1:0] active_of(input logic [ctmt_pkg::CFG_W-1:0] n);
    logic [AW-1:0] r;
    if (32'(n) > 32'(MAX_ENTRIES)) r = AW'(MAX_ENTRIES);
    else r = AW'(n);
    return r;
  endfunction

  assign active   = active_of(entries_in_use);
  assign in_range = 32'(item.entry) < 32'(active);
  assign scan_rd  = cmd.scan_step && (scan_idx < active);

  always_comb begin
    new_c    = rd_data;
    do_wr    = 1'b0;
    sat      = 1'b0;
    lower    = 1'b0;
    rescan   = 1'b0;
    max_next = cur_max;
    cnt_next = cnt_max;
    if (in_range) begin
      case (item.func)
        ctmt_pkg::FUNC_INC: begin
          if (rd_data == '1) begin
            sat = 1'b1;
          end else begin
            new_c = rd_data + CW'(1);
            do_wr = 1'b1;
            if (new_c > cur_max) begin
              max_next = new_c;
              cnt_next = AW'(1);
            end else if (new_c == cur_max) begin
              cnt_next = cnt_max + AW'(1);
            end
          end
        end
        ctmt_pkg::FUNC_DEC: begin
          if (rd_data != '0) begin
            new_c = rd_data - CW'(1);
            do_wr = 1'b1;
            lower = 1'b1;
          end
        end
        ctmt_pkg::FUNC_CLR: begin
          if (rd_data != '0) begin
            new_c = '0;
            do_wr = 1'b1;
            lower = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
    // An entry leaving the maximum: the last one there forces a full rescan.
    if (lower && (rd_data == cur_max)) begin
      if (cnt_max > AW'(1)) cnt_next = cnt_max - AW'(1);
      else rescan = 1'b1;
    end
  end

  assign res_count_c = in_range ? new_c : '0;
  assign status_c    = !in_range ? ctmt_pkg::STATUS_RANGE :
                       sat       ? ctmt_pkg::STATUS_SAT : ctmt_pkg::STATUS_OK;

  assign stat.clr_last    = (clr_idx == IW'(MAX_ENTRIES - 1));
  assign stat.need_rescan = rescan;
  assign stat.scan_done   = (scan_idx == active) && !scan_pend;

  // Counter memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.clr_step) begin
      mem[clr_idx] <= '0;
    end else if (cmd.exec && do_wr) begin
      mem[IW'(item.entry)] <= new_c;
    end
    if (cmd.accept) begin
      rd_data <= mem[IW'(in_data.entry)];
    end else if (scan_rd) begin
      rd_data <= mem[scan_idx[IW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entries_in_use <= ctmt_pkg::CFG_RESET;
      cur_max        <= '0;
      cnt_max        <= active_of(ctmt_pkg::CFG_RESET);
      clr_idx        <= '0;
      scan_idx       <= '0;
      scan_pend      <= 1'b0;
    end else if (cmd.cfg_write) begin
      entries_in_use <= cfg_data;
      cur_max        <= '0;
      cnt_max        <= active_of(cfg_data);
      clr_idx        <= '0;
    end else begin
      if (cmd.clr_step) begin
        clr_idx <= clr_idx + IW'(1);
      end
      if (cmd.exec && !rescan) begin
        cur_max <= max_next;
        cnt_max <= cnt_next;
      end
      if (cmd.scan_start) begin
        cur_max   <= '0;
        cnt_max   <= '0;
        scan_idx  <= '0;
        scan_pend <= 1'b0;
      end else if (cmd.scan_step) begin
        scan_pend <= scan_rd;
        if (scan_rd) begin
          scan_idx <= scan_idx + AW'(1);
        end
        if (scan_pend) begin
          if (rd_data > cur_max) begin
            cur_max <= rd_data;
            cnt_max <= AW'(1);
          end else if (rd_data == cur_max) begin
            cnt_max <= cnt_max + AW'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      item <= in_data;
    end
    if (cmd.exec) begin
      res_count  <= res_count_c;
      res_status <= status_c;
    end
    if (cmd.load_out) begin
      if (cmd.exec) begin
        out_data.entry_count    <= ctmt_pkg::OUT_COUNT_W'(res_count_c);
        out_data.max_count      <= ctmt_pkg::OUT_COUNT_W'(max_next);
        out_data.entries_at_max <= ctmt_pkg::AT_MAX_W'(cnt_next);
        out_data.status         <= status_c;
      end else begin
        out_data.entry_count    <= ctmt_pkg::OUT_COUNT_W'(res_count);
        out_data.max_count      <= ctmt_pkg::OUT_COUNT_W'(cur_max);
        out_data.entries_at_max <= ctmt_pkg::AT_MAX_W'(cnt_max);
        out_data.status         <= res_status;
      end
    end
  end

endmodule

[src/ctmt_ctrl.sv]
module ctmt_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 cfg_valid,
  output logic                 out_valid,
  input  logic                 out_stall,
  output ctmt_pkg::ctmt_cmd_t  cmd,
  input  ctmt_pkg::ctmt_stat_t stat
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_FIN
  } state_t;

  state_t state;
  logic   out_free;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != ST_IDLE) || cfg_valid;

  always_comb begin
    cmd.cfg_write  = cfg_valid;
    cmd.clr_step   = (state == ST_CLEAR) && !cfg_valid;
    cmd.accept     = (state == ST_IDLE) && in_valid && !cfg_valid;
    cmd.exec       = (state == ST_EXEC) && out_free;
    cmd.scan_start = cmd.exec && stat.need_rescan;
    cmd.scan_step  = (state == ST_SCAN);
    cmd.load_out   = (cmd.exec && !stat.need_rescan) || ((state == ST_FIN) && out_free);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      out_valid <= 1'b0;
    end else begin
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (cfg_valid) begin
        state <= ST_CLEAR;
      end else begin
        case (state)
          ST_CLEAR: begin
            if (stat.clr_last) state <= ST_IDLE;
          end
          ST_IDLE: begin
            if (in_valid) state <= ST_EXEC;
          end
          ST_EXEC: begin
            if (out_free) state <= stat.need_rescan ? ST_SCAN : ST_IDLE;
          end
          ST_SCAN: begin
            if (stat.scan_done) state <= ST_FIN;
          end
          ST_FIN: begin
            if (out_free) state <= ST_IDLE;
          end
          default: begin
            state <= ST_CLEAR;
          end
        endcase
      end
    end
  end

endmodule

[src/counter_table_max_tracker.sv]
// Table of saturating per-entry counters that also reports the largest count
// and how many active entries hold it. An ordinary item is read from the table
// memory when it is taken, then updated and loaded into the output register,
// which waits while the output is stalled. When the only entry at the maximum
// moves down, the table is rescanned through the same memory read port, one
// entry per cycle, before the item's result is output. After reset and after
// every write of entries_in_use the whole table is cleared, one entry per cycle
// while no new write comes, and input is stalled until the clear is done. The
// configuration port is always ready.
module counter_table_max_tracker #(
  parameter int MAX_ENTRIES = ctmt_pkg::DEF_MAX_ENTRIES,
  parameter int COUNT_BITS  = ctmt_pkg::DEF_COUNT_BITS
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  ctmt_pkg::in_item_t         in_data,
  output logic                       out_valid,
  input  logic                       out_stall,
  output ctmt_pkg::out_item_t        out_data,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [ctmt_pkg::CFG_W-1:0] cfg_data
);

  ctmt_pkg::ctmt_cmd_t  cmd;
  ctmt_pkg::ctmt_stat_t stat;

  assign cfg_ready = 1'b1;

  ctmt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .cfg_valid (cfg_valid),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .stat      (stat)
  );

  ctmt_dp #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .COUNT_BITS  (COUNT_BITS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .stat     (stat),
    .in_data  (in_data),
    .cfg_data (cfg_data),
    .out_data (out_data)
  );

  // Each item is worked on alone, so a transfer in is never followed at once
  // by another.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken while an item is still in work");

  a_cfg_clears: assert property (@(posedge clk) disable iff (rst)
    (cfg_valid && cfg_ready) |=> in_stall)
    else $error("input not held off during table clear");

  a_range_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_data.status == ctmt_pkg::STATUS_RANGE)) |->
      (out_data.entry_count == '0))
    else $error("out of range result carries a nonzero count");

  a_max_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((COUNT_BITS > 16) || (out_data.max_count >= out_data.entry_count)))
    else $error("entry count above reported maximum");

endmodule
